/* hw/rtl/mbrs_pkg.sv */
// Shared types, codes and CRC helper for the Modbus RTU slave engine.
package mbrs_pkg;

  localparam int          DEF_FRAME_DEPTH    = 64;
  localparam int          DEF_STORE_DEPTH    = 1024;
  localparam int          DEF_MAX_READ_WORDS = 16;
  localparam int          DEF_MAX_READ_BITS  = 16;

  localparam logic [7:0]  ADDR_RESET = 8'h01;
  localparam logic [15:0] STORE_INIT_BASE = 16'h3300;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] COIL_ON = 16'hFFFF;

  localparam logic [7:0]  FN_READ_COILS  = 8'h01;
  localparam logic [7:0]  FN_READ_REGS   = 8'h03;
  localparam logic [7:0]  FN_WRITE_COIL  = 8'h05;
  localparam logic [7:0]  FN_WRITE_REG   = 8'h06;
  localparam logic [7:0]  FN_WRITE_COILS = 8'h0F;
  localparam logic [7:0]  FN_WRITE_REGS  = 8'h10;

  typedef enum logic [3:0] {
    S_INIT, S_RX, S_CHK, S_WB0, S_WB1, S_WB2, S_WBIT, S_HDR,
    S_RDA, S_RDD, S_DHI, S_DLO, S_DB, S_CRC0, S_CRC1
  } state_t;

  typedef struct packed {
    logic        we;
    logic [15:0] addr;
    logic [15:0] data;
  } st_wr_t;

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

endpackage

/* hw/rtl/mbrs_fbuf.sv */
// Frame buffer: one write port, one registered read port.
module mbrs_fbuf #(
  parameter int FRAME_DEPTH = 64,
  parameter int FAW = $clog2(FRAME_DEPTH)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [FAW-1:0] waddr,
  input  logic [7:0]     wdata,
  input  logic [FAW-1:0] raddr,
  output logic [7:0]     rdata
);
  logic [7:0] mem [FRAME_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

/* hw/rtl/mbrs_store.sv */
// Register store with an initialising pass after reset; out-of-range reads give 0.
module mbrs_store #(
  parameter int STORE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mbrs_pkg::st_wr_t   wr,
  input  logic [15:0]        raddr,
  output logic [15:0]        rdata,
  output logic               ready
);
  import mbrs_pkg::*;

  localparam int SAW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic [15:0]    mem [STORE_DEPTH];
  logic [15:0]    rdata_r;
  logic [SAW-1:0] init_idx_r;
  logic           init_busy_r;
  logic           w_in;
  logic           r_in;

  assign w_in = {1'b0, wr.addr} < 17'(STORE_DEPTH);
  assign r_in = {1'b0, raddr} < 17'(STORE_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_idx_r  <= '0;
      init_busy_r <= 1'b1;
    end else if (init_busy_r) begin
      init_idx_r <= init_idx_r + 1'b1;
      if (init_idx_r == SAW'(STORE_DEPTH - 1)) begin
        init_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (init_busy_r) begin
      mem[init_idx_r] <= STORE_INIT_BASE + 16'(init_idx_r);
    end else if (wr.we && w_in) begin
      mem[wr.addr[SAW-1:0]] <= wr.data;
    end
    rdata_r <= r_in ? mem[raddr[SAW-1:0]] : 16'h0000;
  end

  assign rdata = rdata_r;
  assign ready = !init_busy_r;
endmodule

/* hw/rtl/modbus_rtu_slave_engine.sv */
// Top level: Modbus RTU slave frame receiver, request server and response sender.
//
// Input channel (in_valid/in_ready): one received byte per transaction;
// in_frame_start empties the frame buffer before the byte is stored.
// Output channel (out_valid/out_ready): response bytes in send order,
// out_tx_last on the final byte. Configuration: cfg_we writes
// cfg_slave_address at once; write it only while the block is idle.
// Each stored byte goes through S_RX (store), then S_CHK (judge); a dropped
// byte stays in S_RX. A completed frame is served by one sequencer over the
// register store, whose single read port is registered: a register read steps
// through S_RDA, S_RDD, S_DHI and S_DLO per word, a coil read through S_RDA
// and S_RDD per coil plus S_DB per data byte, a register write through S_WB0,
// S_WB1 and S_WB2 per word (two frame buffer reads), a coil write through
// S_WBIT per coil plus S_WB0 and S_WB1 per data byte, then the response is
// sent. No byte is taken until the response is fully handed to the output
// register. After reset the store is filled with index plus 0x3300, and
// in_ready stays low until that pass is over. A stalled receiver holds the
// current byte in the output register and the sequencer waits on it.
module modbus_rtu_slave_engine #(
  parameter int FRAME_DEPTH    = mbrs_pkg::DEF_FRAME_DEPTH,
  parameter int STORE_DEPTH    = mbrs_pkg::DEF_STORE_DEPTH,
  parameter int MAX_READ_WORDS = mbrs_pkg::DEF_MAX_READ_WORDS,
  parameter int MAX_READ_BITS  = mbrs_pkg::DEF_MAX_READ_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       in_frame_start,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_tx_byte,
  output logic       out_tx_last,
  input  logic       cfg_we,
  input  logic [7:0] cfg_slave_address
);
  import mbrs_pkg::*;

  localparam int FAW = $clog2(FRAME_DEPTH);
  localparam int LW  = $clog2(FRAME_DEPTH + 1);

  state_t      state_r, state_nxt;
  logic [7:0]  slave_r;
  logic [LW-1:0] len_r, len_nxt;
  logic [7:0]  hdr_r [8];
  logic [15:0] crc_run_r, crc_p1_r, crc_p2_r;
  logic [7:0]  b_p1_r, b_p2_r;
  logic [15:0] crc_tx_r, crc_tx_nxt;
  logic [15:0] i_r, i_nxt;
  logic [2:0]  hk_r, hk_nxt;
  logic [7:0]  bits_r, bits_nxt;
  logic [15:0] word_r, word_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  logic        acc;
  logic [LW-1:0] eff_len;
  logic        drop;
  logic [15:0] crc_base;
  logic [7:0]  fn;
  logic [15:0] addr_w, cnt_w;
  logic [17:0] need;
  logic        fn_short, fn_long, frame_ok;
  logic        slot, emit, elast;
  logic [7:0]  ebyte;
  logic [15:0] fb_ridx;
  logic [FAW-1:0] fb_raddr;
  logic [7:0]  fb_rdata;
  logic [15:0] st_rdata;
  logic        st_ready;
  st_wr_t      st_wr;

  mbrs_fbuf #(.FRAME_DEPTH(FRAME_DEPTH)) u_fbuf (
    .clk   (clk),
    .we    (acc && !drop),
    .waddr (eff_len[FAW-1:0]),
    .wdata (in_rx_byte),
    .raddr (fb_raddr),
    .rdata (fb_rdata)
  );

  mbrs_store #(.STORE_DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (st_wr),
    .raddr (addr_w + i_r),
    .rdata (st_rdata),
    .ready (st_ready)
  );

  assign in_ready = (state_r == S_RX);
  assign acc      = in_valid && in_ready;
  assign eff_len  = in_frame_start ? '0 : len_r;
  assign drop     = ({1'b0, eff_len} >= (LW+1)'(FRAME_DEPTH));
  assign crc_base = in_frame_start ? CRC_INIT : crc_run_r;

  assign fn     = hdr_r[1];
  assign addr_w = {hdr_r[2], hdr_r[3]};
  assign cnt_w  = {hdr_r[4], hdr_r[5]};
  assign fn_short = (fn == FN_READ_COILS) || (fn == FN_READ_REGS) ||
                    (fn == FN_WRITE_COIL) || (fn == FN_WRITE_REG);
  assign fn_long  = (fn == FN_WRITE_COILS) || (fn == FN_WRITE_REGS);
  assign need = fn_short ? 18'd8 :
                (fn == FN_WRITE_COILS) ? (18'(hdr_r[6]) + 18'd9) :
                ({1'b0, cnt_w, 1'b0} + 18'd9);
  assign frame_ok = (hdr_r[0] == slave_r) && (b_p2_r == crc_p2_r[7:0]) &&
                    (b_p1_r == crc_p2_r[15:8]);

  assign fb_ridx  = (fn == FN_WRITE_COILS) ? (16'd7 + {3'b000, i_r[15:3]}) :
                    (state_r == S_WB1) ? (16'd8 + {i_r[14:0], 1'b0}) :
                    (16'd7 + {i_r[14:0], 1'b0});
  assign fb_raddr = fb_ridx[FAW-1:0];

  assign slot = !out_valid_r || out_ready;

  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    crc_tx_nxt = crc_tx_r;
    i_nxt      = i_r;
    hk_nxt     = hk_r;
    bits_nxt   = bits_r;
    word_nxt   = word_r;
    hi_nxt     = hi_r;
    emit       = 1'b0;
    ebyte      = 8'h00;
    elast      = 1'b0;
    st_wr      = '0;
    unique case (state_r)
      S_INIT: begin
        if (st_ready) state_nxt = S_RX;
      end
      S_RX: begin
        if (acc) begin
          if (drop) begin
            len_nxt = eff_len;
          end else begin
            len_nxt   = eff_len + 1'b1;
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        state_nxt = S_RX;
        if (len_r > LW'(4)) begin
          if (fn_long && len_r < LW'(7)) begin
            state_nxt = S_RX;
          end else if (fn_long && need > 18'(FRAME_DEPTH)) begin
            len_nxt = '0;
          end else if ((fn_short || fn_long) && 18'(len_r) >= need) begin
            len_nxt    = '0;
            crc_tx_nxt = CRC_INIT;
            i_nxt      = '0;
            hk_nxt     = '0;
            bits_nxt   = '0;
            if (frame_ok) begin
              if (fn == FN_READ_COILS) begin
                if (cnt_w <= 16'(MAX_READ_BITS)) state_nxt = S_HDR;
              end else if (fn == FN_READ_REGS) begin
                if (cnt_w <= 16'(MAX_READ_WORDS)) state_nxt = S_HDR;
              end else if (fn == FN_WRITE_COIL || fn == FN_WRITE_REG) begin
                st_wr.we   = 1'b1;
                st_wr.addr = addr_w;
                st_wr.data = cnt_w;
                state_nxt  = S_HDR;
              end else if (fn == FN_WRITE_COILS) begin
                state_nxt = (cnt_w == 16'd0 || hdr_r[6] == 8'd0) ? S_HDR : S_WB0;
              end else begin
                state_nxt = (cnt_w == 16'd0) ? S_HDR : S_WB0;
              end
            end
          end
        end
      end
      S_WB0: state_nxt = S_WB1;
      S_WB1: begin
        if (fn == FN_WRITE_COILS) begin
          bits_nxt  = fb_rdata;
          state_nxt = S_WBIT;
        end else begin
          hi_nxt    = fb_rdata;
          state_nxt = S_WB2;
        end
      end
      S_WB2: begin
        st_wr.we   = 1'b1;
        st_wr.addr = addr_w + i_r;
        st_wr.data = {hi_r, fb_rdata};
        i_nxt      = i_r + 1'b1;
        state_nxt  = (i_nxt == cnt_w) ? S_HDR : S_WB0;
      end
      S_WBIT: begin
        st_wr.we   = 1'b1;
        st_wr.addr = addr_w + i_r;
        st_wr.data = bits_r[i_r[2:0]] ? COIL_ON : 16'h0000;
        i_nxt      = i_r + 1'b1;
        if (i_nxt == cnt_w) begin
          state_nxt = S_HDR;
        end else if (i_nxt[2:0] == 3'd0) begin
          state_nxt = ({3'b000, i_nxt[15:3]} == {8'd0, hdr_r[6]}) ? S_HDR : S_WB0;
        end
      end
      S_HDR: begin
        if (slot) begin
          emit   = 1'b1;
          hk_nxt = hk_r + 1'b1;
          if (fn == FN_WRITE_COIL || fn == FN_WRITE_REG) begin
            ebyte = hdr_r[hk_r];
            elast = (hk_r == 3'd7);
            if (elast) state_nxt = S_RX;
          end else if (fn == FN_READ_COILS || fn == FN_READ_REGS) begin
            case (hk_r)
              3'd0:    ebyte = slave_r;
              3'd1:    ebyte = fn;
              default: ebyte = (fn == FN_READ_COILS) ? 8'((cnt_w + 16'd7) >> 3)
                                                     : {cnt_w[6:0], 1'b0};
            endcase
            if (hk_r == 3'd2) state_nxt = (cnt_w == 16'd0) ? S_CRC0 : S_RDA;
          end else begin
            ebyte = (hk_r == 3'd0) ? slave_r : hdr_r[hk_r];
            if (hk_r == 3'd5) state_nxt = S_CRC0;
          end
        end
      end
      S_RDA: state_nxt = S_RDD;
      S_RDD: begin
        i_nxt = i_r + 1'b1;
        if (fn == FN_READ_REGS) begin
          word_nxt  = st_rdata;
          state_nxt = S_DHI;
        end else begin
          bits_nxt  = bits_r | (8'(st_rdata != 16'h0000) << i_r[2:0]);
          state_nxt = (i_nxt[2:0] == 3'd0 || i_nxt == cnt_w) ? S_DB : S_RDA;
        end
      end
      S_DHI: begin
        if (slot) begin
          emit      = 1'b1;
          ebyte     = word_r[15:8];
          state_nxt = S_DLO;
        end
      end
      S_DLO: begin
        if (slot) begin
          emit      = 1'b1;
          ebyte     = word_r[7:0];
          state_nxt = (i_r == cnt_w) ? S_CRC0 : S_RDA;
        end
      end
      S_DB: begin
        if (slot) begin
          emit      = 1'b1;
          ebyte     = bits_r;
          bits_nxt  = '0;
          state_nxt = (i_r == cnt_w) ? S_CRC0 : S_RDA;
        end
      end
      S_CRC0: begin
        if (slot) begin
          emit      = 1'b1;
          ebyte     = crc_tx_r[7:0];
          state_nxt = S_CRC1;
        end
      end
      S_CRC1: begin
        if (slot) begin
          emit      = 1'b1;
          ebyte     = crc_tx_r[15:8];
          elast     = 1'b1;
          state_nxt = S_RX;
        end
      end
      default: state_nxt = S_INIT;
    endcase
    // CRC0 carries the low byte already; do not fold it into the high byte
    if (emit && state_r != S_CRC0 && state_r != S_CRC1) begin
      crc_tx_nxt = crc_step(crc_tx_r, ebyte);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      len_r       <= '0;
      slave_r     <= ADDR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      if (cfg_we) slave_r <= cfg_slave_address;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    crc_tx_r <= crc_tx_nxt;
    i_r      <= i_nxt;
    hk_r     <= hk_nxt;
    bits_r   <= bits_nxt;
    word_r   <= word_nxt;
    hi_r     <= hi_nxt;
    if (emit) begin
      out_byte_r <= ebyte;
      out_last_r <= elast;
    end
    if (acc && !drop) begin
      if ({1'b0, eff_len} < (LW+1)'(8)) hdr_r[eff_len[2:0]] <= in_rx_byte;
      crc_p2_r  <= crc_p1_r;
      crc_p1_r  <= crc_base;
      crc_run_r <= crc_step(crc_base, in_rx_byte);
      b_p2_r    <= b_p1_r;
      b_p1_r    <= in_rx_byte;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_tx_byte = out_byte_r;
  assign out_tx_last = out_last_r;

`ifndef SYNTH
  a_no_rx_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !st_ready |-> !in_ready) else $error("byte taken during store clear");
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, len_r} <= (LW+1)'(FRAME_DEPTH)) else $error("frame length overflow");
  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    st_wr.we |-> (state_r == S_CHK || state_r == S_WB2 || state_r == S_WBIT))
    else $error("store write outside write states");
  a_acc_next: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (state_r == S_CHK || state_r == S_RX)) else $error("bad state after byte");
  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_ready)) else $error("output overwritten");
`endif
endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the Modbus RTU slave engine: random request frames, CRC checks.
module tb;
  import mbrs_pkg::*;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
  } tx_item_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_rx_byte;
  logic       in_frame_start;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_tx_byte;
  logic       out_tx_last;
  logic       cfg_we;
  logic [7:0] cfg_slave_address;

  rx_item_t   rx_pending[$];
  tx_item_t   tx_expected[$];
  int         err_cnt = 0;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         n_tx_seen = 0;
  int         stall_left = 0;
  bit         stall_done = 1'b0;

  // Shadow state of the slave
  logic [7:0]  sta_addr;
  logic [7:0]  fbuf[64];
  int          flen = 0;
  logic [15:0] regs[1024];

  modbus_rtu_slave_engine u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .in_frame_start    (in_frame_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_tx_byte       (out_tx_byte),
    .out_tx_last       (out_tx_last),
    .cfg_we            (cfg_we),
    .cfg_slave_address (cfg_slave_address)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [15:0] crc16(input logic [7:0] q[$]);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (q[i]) begin
      c = c ^ {8'h00, q[i]};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] reg_read(input logic [15:0] a);
    return (a < 1024) ? regs[a] : 16'h0000;
  endfunction

  task automatic reg_write(input logic [15:0] a, input logic [15:0] v);
    if (a < 1024) regs[a] = v;
  endtask

  task automatic queue_response(input logic [7:0] rsp[$], input bit with_crc);
    logic [15:0] c;
    tx_item_t    t;
    if (with_crc) begin
      c = crc16(rsp);
      rsp.push_back(c[7:0]);
      rsp.push_back(c[15:8]);
    end
    foreach (rsp[i]) begin
      t.tx_byte = rsp[i];
      t.tx_last = (i == rsp.size() - 1);
      tx_expected.push_back(t);
    end
  endtask

  task automatic serve_request(input logic [7:0] fn);
    logic [15:0] base;
    logic [15:0] cnt;
    logic [7:0]  rsp[$];
    logic [7:0]  bits[3];
    int          nb;
    int          done;
    logic [15:0] v;
    base = {fbuf[2], fbuf[3]};
    cnt  = {fbuf[4], fbuf[5]};
    if (fn == FN_READ_COILS) begin
      if (cnt > 16) return;
      nb = (cnt + 7) / 8;
      bits = '{default: 8'h00};
      for (int i = 0; i < cnt; i++)
        if (reg_read(base + 16'(i)) != 0) bits[i / 8][i % 8] = 1'b1;
      rsp = {sta_addr, FN_READ_COILS, 8'(nb)};
      for (int i = 0; i < nb; i++) rsp.push_back(bits[i]);
      queue_response(rsp, 1'b1);
    end else if (fn == FN_READ_REGS) begin
      if (cnt > 16) return;
      rsp = {sta_addr, FN_READ_REGS, 8'(2 * cnt)};
      for (int i = 0; i < cnt; i++) begin
        v = reg_read(base + 16'(i));
        rsp.push_back(v[15:8]);
        rsp.push_back(v[7:0]);
      end
      queue_response(rsp, 1'b1);
    end else if (fn == FN_WRITE_COIL || fn == FN_WRITE_REG) begin
      reg_write(base, cnt);
      for (int i = 0; i < 8; i++) rsp.push_back(fbuf[i]);
      queue_response(rsp, 1'b0);
    end else begin
      if (fn == FN_WRITE_COILS) begin
        done = 0;
        for (int i = 0; i < fbuf[6] && done < cnt; i++)
          for (int k = 0; k < 8 && done < cnt; k++) begin
            reg_write(base + 16'(done), fbuf[7 + i][k] ? COIL_ON : 16'h0000);
            done++;
          end
      end else begin
        for (int i = 0; i < cnt; i++)
          reg_write(base + 16'(i), {fbuf[7 + 2 * i], fbuf[8 + 2 * i]});
      end
      rsp = {sta_addr, fn, base[15:8], base[7:0], cnt[15:8], cnt[7:0]};
      queue_response(rsp, 1'b1);
    end
  endtask

  // Advance the shadow frame receiver by one accepted byte
  task automatic take_rx_byte(input logic [7:0] b, input logic s);
    int          need;
    logic [7:0]  fn;
    logic [7:0]  body[$];
    logic [15:0] c;
    if (s) flen = 0;
    if (flen >= 64) return;
    fbuf[flen] = b;
    flen++;
    if (flen <= 4) return;
    fn = fbuf[1];
    if (fn == FN_READ_COILS || fn == FN_READ_REGS || fn == FN_WRITE_COIL ||
        fn == FN_WRITE_REG) begin
      need = 8;
    end else if (fn == FN_WRITE_COILS || fn == FN_WRITE_REGS) begin
      if (flen < 7) return;
      need = (fn == FN_WRITE_COILS) ? fbuf[6] + 9 : 2 * {fbuf[4], fbuf[5]} + 9;
      if (need > 64) begin
        flen = 0;
        return;
      end
    end else begin
      return;
    end
    if (flen < need) return;
    for (int i = 0; i < need - 2; i++) body.push_back(fbuf[i]);
    c = crc16(body);
    if (fbuf[0] == sta_addr && fbuf[need - 2] == c[7:0] && fbuf[need - 1] == c[15:8])
      serve_request(fn);
    flen = 0;
  endtask

  // Driver: hold the payload while stalled, otherwise offer the next byte
  always @(posedge clk) begin
    rx_item_t nxt;
    if (!rst_n) begin
      in_valid       <= 1'b0;
      in_rx_byte     <= 8'h00;
      in_frame_start <= 1'b0;
    end else begin
      if (in_valid && in_ready) take_rx_byte(in_rx_byte, in_frame_start);
      if (!(in_valid && !in_ready)) begin
        if (rx_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = rx_pending.pop_front();
          in_valid       <= 1'b1;
          in_rx_byte     <= nxt.rx_byte;
          in_frame_start <= nxt.frame_start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each response transaction against the oldest prediction
  always @(posedge clk) begin
    tx_item_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_tx_seen++;
        if (tx_expected.size() == 0) begin
          $error("unexpected response byte %h", out_tx_byte);
          err_cnt++;
        end else begin
          e = tx_expected.pop_front();
          if (out_tx_byte !== e.tx_byte) begin
            $error("tx_byte expected %h actual %h", e.tx_byte, out_tx_byte);
            err_cnt++;
          end
          if (out_tx_last !== e.tx_last) begin
            $error("tx_last expected %b actual %b", e.tx_last, out_tx_last);
            err_cnt++;
          end
        end
        // hold off the receiver once for a long stretch
        if (n_tx_seen == 30 && !stall_done) begin
          stall_done = 1'b1;
          stall_left = 600;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic push_bytes(input logic [7:0] q[$]);
    rx_item_t t;
    foreach (q[i]) begin
      t.rx_byte     = q[i];
      t.frame_start = (i == 0);
      rx_pending.push_back(t);
    end
  endtask

  task automatic push_request(input logic [7:0] body[$], input bit corrupt);
    logic [15:0] c;
    c = crc16(body);
    body.push_back(c[7:0]);
    body.push_back(c[15:8] ^ (corrupt ? 8'(1 << $urandom_range(7)) : 8'h00));
    push_bytes(body);
  endtask

  function automatic logic [15:0] pick_address();
    case ($urandom_range(3))
      0: return 16'($urandom_range(1023));
      1: return 16'($urandom_range(1023, 1008));
      2: return 16'($urandom_range(65535, 1024));
      default: return 16'($urandom_range(65535, 65528));
    endcase
  endfunction

  task automatic push_random_frame();
    logic [7:0]  body[$];
    logic [7:0]  sa;
    logic [7:0]  fn;
    logic [15:0] base;
    logic [15:0] cnt;
    logic [7:0]  nbytes;
    int          kind;
    rx_item_t    t;
    kind = $urandom_range(99);
    if (kind < 4) begin
      // line noise with random frame boundaries
      repeat ($urandom_range(12, 1)) begin
        t.rx_byte     = 8'($urandom);
        t.frame_start = $urandom_range(1);
        rx_pending.push_back(t);
      end
      return;
    end
    if (kind < 7) begin
      // unknown function: random length, at times past the buffer depth
      body = {sta_addr, 8'($urandom_range(255, 17))};
      repeat ($urandom_range(70, 4)) body.push_back(8'($urandom));
      push_bytes(body);
      return;
    end
    sa = ($urandom_range(9) == 0) ? 8'($urandom) : sta_addr;
    case ($urandom_range(5))
      0: fn = FN_READ_COILS;
      1: fn = FN_READ_REGS;
      2: fn = FN_WRITE_COIL;
      3: fn = FN_WRITE_REG;
      4: fn = FN_WRITE_COILS;
      default: fn = FN_WRITE_REGS;
    endcase
    base = pick_address();
    if (fn == FN_READ_COILS || fn == FN_READ_REGS)
      cnt = ($urandom_range(9) == 0) ? 16'($urandom_range(65535, 17)) : 16'($urandom_range(16));
    else if (fn == FN_WRITE_COILS)
      cnt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(40));
    else if (fn == FN_WRITE_REGS)
      cnt = ($urandom_range(14) == 0) ? 16'($urandom_range(65535, 28)) : 16'($urandom_range(6));
    else
      cnt = 16'($urandom);
    body = {sa, fn, base[15:8], base[7:0], cnt[15:8], cnt[7:0]};
    if (fn == FN_WRITE_COILS) begin
      nbytes = ($urandom_range(14) == 0) ? 8'($urandom_range(255, 56)) : 8'($urandom_range(6));
      body.push_back(nbytes);
      if (nbytes > 55) begin
        push_bytes(body);
        return;
      end
      repeat (nbytes) body.push_back(8'($urandom));
    end else if (fn == FN_WRITE_REGS) begin
      body.push_back(8'(2 * cnt));
      if (2 * cnt + 9 > 64) begin
        push_bytes(body);
        return;
      end
      repeat (2 * cnt) body.push_back(8'($urandom));
    end
    push_request(body, $urandom_range(11) == 0);
  endtask

  task automatic wait_drained();
    while (rx_pending.size() > 0 || in_valid || tx_expected.size() > 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_address(input logic [7:0] a);
    @(posedge clk);
    cfg_we            <= 1'b1;
    cfg_slave_address <= a;
    @(posedge clk);
    cfg_we <= 1'b0;
    sta_addr = a;
    @(negedge clk);
  endtask

  initial begin
    int target;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_slave_address = 8'h00;
    send_idle_pct     = 11;
    recv_idle_pct     = 51;
    sta_addr          = ADDR_RESET;
    for (int i = 0; i < 1024; i++) regs[i] = STORE_INIT_BASE + 16'(i);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: full coil read, empty read at the wrap point, write at store end
    push_request('{8'h01, FN_READ_COILS, 8'h00, 8'h00, 8'h00, 8'h10}, 1'b0);
    push_request('{8'h01, FN_READ_REGS, 8'hFF, 8'hFF, 8'h00, 8'h00}, 1'b0);
    push_request('{8'h01, FN_WRITE_REG, 8'h03, 8'hFF, 8'hFF, 8'hFF}, 1'b0);

    for (int p = 0; p < 4; p++) begin
      case (p)
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 11;
          write_address(8'h00);
        end
        2: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_address(8'hFF);
        end
        3: write_address(8'($urandom));
        default: ;
      endcase
      target = rx_pending.size() + 65;
      while (rx_pending.size() < target) push_random_frame();
      wait_drained();
    end

    if (err_cnt == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #40000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* modbus_rtu_slave_engine.f */
hw/rtl/mbrs_pkg.sv
hw/rtl/mbrs_fbuf.sv
hw/rtl/mbrs_store.sv
hw/rtl/modbus_rtu_slave_engine.sv
tb/sv/tb.sv
